### src/tga_dec_pkg.sv
// tga_dec_pkg: word types, mode codes, image kinds and register indexes
// shared by the tga pixel stream decoder modules other than tga_dec_pal_mem
// no dependencies
`default_nettype none

package tga_dec_pkg;

    // input word modes
    localparam logic [1:0] MODE_DATA  = 2'd0;
    localparam logic [1:0] MODE_MAP   = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    // image kinds
    localparam logic [2:0] KIND_MAP8   = 3'd0;
    localparam logic [2:0] KIND_TRUE16 = 3'd1;
    localparam logic [2:0] KIND_TRUE24 = 3'd2;
    localparam logic [2:0] KIND_TRUE32 = 3'd3;
    localparam logic [2:0] KIND_GREY8  = 3'd4;
    localparam logic [2:0] KIND_GREY16 = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_KIND  = 2'd0;
    localparam logic [1:0] CFG_RLE   = 2'd1;
    localparam logic [1:0] CFG_TOTAL = 2'd2;

    localparam int CFG_DATA_W = 24;

    // rle packet header fields
    localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;
    localparam logic [7:0] HDR_RUN_BIT    = 8'h80;

    // input word
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  data_byte;
        logic [7:0]  map_index;
        logic [23:0] map_entry;
    } item_word_t;

    // result word
    typedef struct packed {
        logic [7:0] chan_first;
        logic [7:0] chan_second;
        logic [7:0] chan_third;
        logic [7:0] chan_fourth;
        logic [7:0] repeat_count;
        logic       image_last;
    } pix_word_t;

    // assembled pixel waiting for palette data and formatting
    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] gather;
        logic [7:0]  top_byte;
        logic [7:0]  rep;
        logic        last;
        logic        pal_hit;
    } pix_stage_t;

    // bytes per pixel for a kind, zero for unused codes
    function automatic logic [2:0] kind_bytes(input logic [2:0] kind);
        logic [2:0] n;
        case (kind)
            KIND_MAP8:   n = 3'd1;
            KIND_TRUE16: n = 3'd2;
            KIND_TRUE24: n = 3'd3;
            KIND_TRUE32: n = 3'd4;
            KIND_GREY8:  n = 3'd1;
            KIND_GREY16: n = 3'd2;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

### src/tga_dec_pal_mem.sv
// tga_dec_pal_mem: colormap memory, one write port and one registered read port
// depends on nothing
`default_nettype none

module tga_dec_pal_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [23:0]   wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic [23:0]        rdata
);

    logic [23:0] mem [DEPTH];
    logic [23:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/tga_dec_pkt.sv
// tga_dec_pkt: rle packet tracking, pixel byte assembly and pixel count,
// with the stage register that holds one assembled pixel; uses tga_dec_pkg
`default_nettype none

module tga_dec_pkt
    import tga_dec_pkg::*;
#(
    parameter int COUNT_WIDTH = 24,
    parameter int AW          = 8,
    parameter int DEPTH       = 256
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire item_word_t             item,
    input  wire logic [2:0]             kind,
    input  wire logic                   rle_on,
    input  wire logic [23:0]            pixel_total,
    input  wire logic                   stage_take,
    output logic                        stage_valid,
    output pix_stage_t                  stage,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    output logic [COUNT_WIDTH-1:0]      pixels_left
);

    logic [7:0]             packet_left_reg, packet_left_next;
    logic                   packet_run_reg, packet_run_next;
    logic                   expect_header_reg, expect_header_next;
    logic [1:0]             byte_slot_reg, byte_slot_next;
    logic [23:0]            gather_reg, gather_next;
    logic [COUNT_WIDTH-1:0] pixels_left_reg, pixels_left_next;
    logic                   stage_valid_reg, stage_valid_next;
    pix_stage_t             stage_reg, stage_next;

    logic [2:0]  need;
    logic [23:0] shifted;
    logic [23:0] full;
    logic [7:0]  rep;
    logic        load;

    assign need = kind_bytes(kind);

    // current byte placed at its slot in the little-endian pixel
    always_comb
    begin
        case (byte_slot_reg)
            2'd0:    shifted = {16'd0, item.data_byte};
            2'd1:    shifted = {8'd0, item.data_byte, 8'd0};
            2'd2:    shifted = {item.data_byte, 16'd0};
            default: shifted = 24'd0;
        endcase
        full = gather_reg | shifted;
    end

    // packet and assembly state update for one accepted word
    always_comb
    begin
        packet_left_next   = packet_left_reg;
        packet_run_next    = packet_run_reg;
        expect_header_next = expect_header_reg;
        byte_slot_next     = byte_slot_reg;
        gather_next        = gather_reg;
        pixels_left_next   = pixels_left_reg;
        rep                = 8'd1;
        load               = 1'b0;

        if (accept)
        begin
            case (item.mode)
                MODE_START:
                begin
                    pixels_left_next   = COUNT_WIDTH'(pixel_total);
                    expect_header_next = 1'b1;
                    packet_left_next   = 8'd0;
                    packet_run_next    = 1'b0;
                    byte_slot_next     = 2'd0;
                    gather_next        = 24'd0;
                end
                MODE_DATA:
                begin
                    if (pixels_left_reg != '0 && need != 3'd0)
                    begin
                        if (rle_on && expect_header_reg)
                        begin
                            // packet header byte
                            packet_run_next    = |(item.data_byte & HDR_RUN_BIT);
                            packet_left_next   = (item.data_byte & HDR_COUNT_MASK) + 8'd1;
                            expect_header_next = 1'b0;
                            byte_slot_next     = 2'd0;
                            gather_next        = 24'd0;
                        end
                        else if ({1'b0, byte_slot_reg} + 3'd1 < need)
                        begin
                            gather_next    = full;
                            byte_slot_next = byte_slot_reg + 2'd1;
                        end
                        else
                        begin
                            // last byte of the pixel
                            load           = 1'b1;
                            byte_slot_next = 2'd0;
                            gather_next    = 24'd0;
                            if (rle_on && packet_run_reg)
                            begin
                                if (COUNT_WIDTH'(packet_left_reg) > pixels_left_reg)
                                begin
                                    rep = pixels_left_reg[7:0];
                                end
                                else
                                begin
                                    rep = packet_left_reg;
                                end
                                packet_left_next   = 8'd0;
                                expect_header_next = 1'b1;
                            end
                            else if (rle_on)
                            begin
                                packet_left_next = packet_left_reg - 8'd1;
                                if (packet_left_reg == 8'd1)
                                begin
                                    expect_header_next = 1'b1;
                                end
                            end
                            pixels_left_next = pixels_left_reg - COUNT_WIDTH'(rep);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // stage register contents
    always_comb
    begin
        stage_next.kind     = kind;
        stage_next.gather   = full;
        stage_next.top_byte = item.data_byte;
        stage_next.rep      = rep;
        stage_next.last     = (pixels_left_next == '0);
        stage_next.pal_hit  = ({1'b0, full[7:0]} < 9'(DEPTH));
        stage_valid_next    = load | (stage_valid_reg & ~stage_take);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_left_reg   <= 8'd0;
            packet_run_reg    <= 1'b0;
            expect_header_reg <= 1'b1;
            byte_slot_reg     <= 2'd0;
            gather_reg        <= 24'd0;
            pixels_left_reg   <= '0;
            stage_valid_reg   <= 1'b0;
        end
        else
        begin
            packet_left_reg   <= packet_left_next;
            packet_run_reg    <= packet_run_next;
            expect_header_reg <= expect_header_next;
            byte_slot_reg     <= byte_slot_next;
            gather_reg        <= gather_next;
            pixels_left_reg   <= pixels_left_next;
            stage_valid_reg   <= stage_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;
    assign rd_en       = load;
    assign rd_addr     = full[AW-1:0];
    assign pixels_left = pixels_left_reg;

endmodule

`default_nettype wire

### src/tga_dec_out.sv
// tga_dec_out: channel formatting per image kind and the result register
// uses tga_dec_pkg
`default_nettype none

module tga_dec_out
    import tga_dec_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        stage_valid,
    input  wire pix_stage_t  stage,
    input  wire logic [23:0] pal_data,
    output logic             stage_take,
    output logic             pix_valid,
    input  wire logic        pix_ready,
    output pix_word_t        pix
);

    logic      pix_valid_reg, pix_valid_next;
    pix_word_t pix_reg, pix_next;
    logic [7:0] b0, b1, b2;

    assign b0 = stage.gather[7:0];
    assign b1 = stage.gather[15:8];
    assign b2 = stage.gather[23:16];

    // result register takes a pixel when empty or being drained
    assign stage_take = stage_valid & (~pix_valid_reg | pix_ready);

    // bgr(a) to rgb(a), 5-5-5 expansion, palette lookup, grey pass-through
    always_comb
    begin
        pix_next              = '0;
        pix_next.repeat_count = stage.rep;
        pix_next.image_last   = stage.last;
        case (stage.kind)
            KIND_MAP8:
            begin
                if (stage.pal_hit)
                begin
                    pix_next.chan_first  = pal_data[23:16];
                    pix_next.chan_second = pal_data[15:8];
                    pix_next.chan_third  = pal_data[7:0];
                end
            end
            KIND_TRUE16:
            begin
                pix_next.chan_first  = {b1[6:2], 3'b000};
                pix_next.chan_second = {b1[1:0], b0[7:5], 3'b000};
                pix_next.chan_third  = {b0[4:0], 3'b000};
            end
            KIND_TRUE24:
            begin
                pix_next.chan_first  = b2;
                pix_next.chan_second = b1;
                pix_next.chan_third  = b0;
            end
            KIND_TRUE32:
            begin
                pix_next.chan_first  = b2;
                pix_next.chan_second = b1;
                pix_next.chan_third  = b0;
                pix_next.chan_fourth = stage.top_byte;
            end
            KIND_GREY8:
            begin
                pix_next.chan_first = b0;
            end
            default:
            begin
                pix_next.chan_first  = b0;
                pix_next.chan_second = b1;
            end
        endcase
    end

    assign pix_valid_next = stage_valid | (pix_valid_reg & ~pix_ready);

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (stage_take)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

endmodule

`default_nettype wire

### src/tga_pixel_stream_decoder_core.sv
// tga_pixel_stream_decoder_core: top level of the tga pixel stream decoder
// uses tga_dec_pkg, tga_dec_pkt, tga_dec_pal_mem, tga_dec_out
//
// Usage:
//   item channel (item_valid/item_ready/item) takes one word per cycle while
//   ready: a pixel data byte, a colormap entry write or a new image start.
//   pix channel (pix_valid/pix_ready/pix) gives one decoded pixel with its
//   repeat count each time the last byte of a pixel arrives.
//   cfg_we/cfg_index/cfg_wdata set image kind, rle enable and pixel total;
//   write them only while no word is in flight.
// Timing:
//   after the word holding its last byte is taken, a pixel passes through
//   the pixel stage with the colormap read, then the result register, to pix.
//   One word per cycle while item_ready is high; the rate is set by the
//   single pass of packet and assembly logic feeding the stage.
// Reset:
//   clears packet state and pixel count and sets kind to 24-bit true color;
//   colormap contents stay undefined until written.
// Stall:
//   with pix_ready low, one pixel waits in the result register and one in the
//   pixel stage; item_ready drops only when both are full.
`default_nettype none

module tga_pixel_stream_decoder_core
    import tga_dec_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256,
    parameter int COUNT_WIDTH   = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire item_word_t            item,
    output logic                       pix_valid,
    input  wire logic                  pix_ready,
    output pix_word_t                  pix,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [2:0]  kind_reg;
    logic        rle_reg;
    logic [23:0] total_reg;

    logic                   accept;
    logic                   stage_valid;
    logic                   stage_take;
    pix_stage_t             stage;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [23:0]            pal_data;
    logic                   map_we;
    logic [COUNT_WIDTH-1:0] pixels_left;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_TRUE24;
            rle_reg   <= 1'b0;
            total_reg <= 24'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KIND:  kind_reg  <= cfg_wdata[2:0];
                CFG_RLE:   rle_reg   <= cfg_wdata[0];
                CFG_TOTAL: total_reg <= cfg_wdata[23:0];
                default:
                begin
                end
            endcase
        end
    end

    // input handshake: stall only when the pixel stage is full and stuck
    assign item_ready = ~stage_valid | stage_take;
    assign accept     = item_valid & item_ready;

    // colormap writes
    assign map_we = accept && (item.mode == MODE_MAP)
                    && ({1'b0, item.map_index} < 9'(PALETTE_DEPTH));

    tga_dec_pkt #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .AW          (AW),
        .DEPTH       (PALETTE_DEPTH)
    ) u_pkt (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .kind        (kind_reg),
        .rle_on      (rle_reg),
        .pixel_total (total_reg),
        .stage_take  (stage_take),
        .stage_valid (stage_valid),
        .stage       (stage),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .pixels_left (pixels_left)
    );

    tga_dec_pal_mem #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_pal (
        .clk   (clk),
        .we    (map_we),
        .waddr (item.map_index[AW-1:0]),
        .wdata (item.map_entry),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (pal_data)
    );

    tga_dec_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .pal_data    (pal_data),
        .stage_take  (stage_take),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pix         (pix)
    );

`ifndef SYNTHESIS
    // a full, stuck pixel stage must hold off new words
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && !stage_take) |-> !item_ready)
        else $error("word accepted while pixel stage is blocked");

    // every result covers at least one pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid |-> (stage.rep != 8'd0))
        else $error("pixel with zero repeat count");

    // a pixel marked last leaves no pixels in the count
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && stage.last) |-> (pixels_left == '0))
        else $error("last pixel flagged with pixels still left");
`endif

endmodule

`default_nettype wire

### verif/tga_pixel_stream_decoder_core_tb.sv
// tga_pixel_stream_decoder_core_tb: self-checking bench for the tga pixel stream decoder
// drives image data, colormap and start words against a cycle-free decode predictor
// depends on tga_dec_pkg and tga_pixel_stream_decoder_core
`default_nettype none

module tga_pixel_stream_decoder_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tga_dec_pkg::*;

    // word codes the package leaves unnamed
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [2:0] KIND_SPARE = 3'd7;

    // watchdog limit, with a wide margin over the slowest legal run
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 6;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_WORDS = 1150;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    item_word_t item       = '0;
    logic       pix_valid;
    logic       pix_ready  = 1'b0;
    pix_word_t  pix;
    logic       cfg_we     = 1'b0;
    logic [1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor state
    logic [23:0] pal_mem [256];
    int unsigned pkt_left;
    bit          pkt_run;
    bit          hdr_due;
    int unsigned slot;
    int unsigned gather_acc;
    int unsigned px_left;
    logic [2:0]  kind_r;
    bit          rle_r;
    int unsigned total_r;

    pix_word_t   pixels_due [$];
    int          errors;
    int          cycle_count;
    int          body_words;
    bit          quiet;
    int unsigned hold_asks;
    int unsigned hold_seen;
    int          hold_left;
    int          stall_left;

    tga_pixel_stream_decoder_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix        (pix),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // bytes per pixel of a kind, zero for unused kinds
    function automatic int unsigned pixel_width(input logic [2:0] kind);
        case (kind)
            KIND_MAP8, KIND_GREY8:    return 1;
            KIND_TRUE16, KIND_GREY16: return 2;
            KIND_TRUE24:              return 3;
            KIND_TRUE32:              return 4;
            default:                  return 0;
        endcase
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'h00;
        else if (r < 20)
            return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned pick_count(input bit run);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 8);
        else if (r < 90 || !run)
            return $urandom_range(9, 32);
        return $urandom_range(33, 128);
    endfunction

    function automatic item_word_t data_word(input logic [7:0] b);
        item_word_t w;
        w.mode      = MODE_DATA;
        w.data_byte = b;
        w.map_index = 8'($urandom);
        w.map_entry = 24'($urandom);
        return w;
    endfunction

    function automatic item_word_t map_word(input logic [7:0] idx, input logic [23:0] entry);
        item_word_t w;
        w.mode      = MODE_MAP;
        w.data_byte = 8'($urandom);
        w.map_index = idx;
        w.map_entry = entry;
        return w;
    endfunction

    function automatic item_word_t start_word();
        item_word_t w;
        w           = item_word_t'({$urandom, $urandom});
        w.mode      = MODE_START;
        return w;
    endfunction

    // stray words: colormap writes, spare mode, loose bytes, early restarts
    function automatic item_word_t noise_word();
        item_word_t w;
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            w = map_word(8'($urandom), 24'($urandom));
        else if (r < 7)
        begin
            w      = item_word_t'({$urandom, $urandom});
            w.mode = MODE_SPARE;
        end
        else if (r < 9)
            w = data_word(pick_byte());
        else
            w = start_word();
        return w;
    endfunction

    // decode one accepted word into the expected pixel queue
    task automatic decode_word(input item_word_t w);
        int unsigned need;
        int unsigned byt;
        int unsigned b0;
        int unsigned b1;
        int unsigned b2;
        int unsigned c;
        int unsigned r;
        int unsigned g;
        int unsigned bl;
        int unsigned a;
        int unsigned rep;
        pix_word_t   p;
        byt  = w.data_byte;
        need = pixel_width(kind_r);
        if (w.mode == MODE_MAP)
            pal_mem[w.map_index] = w.map_entry;
        else if (w.mode == MODE_START)
        begin
            px_left    = total_r & 32'hffffff;
            hdr_due    = 1'b1;
            pkt_left   = 0;
            pkt_run    = 1'b0;
            slot       = 0;
            gather_acc = 0;
        end
        else if (w.mode == MODE_DATA && px_left != 0 && need != 0)
        begin
            if (rle_r && hdr_due)
            begin
                // packet header: run flag and count
                pkt_run    = (byt & HDR_RUN_BIT) != 0;
                pkt_left   = (byt & HDR_COUNT_MASK) + 1;
                hdr_due    = 1'b0;
                slot       = 0;
                gather_acc = 0;
            end
            else if (slot + 1 < need)
            begin
                gather_acc = (gather_acc | (byt << (8 * slot))) & 32'hffffff;
                slot       = (slot + 1) & 3;
            end
            else
            begin
                // last byte of the pixel
                if (slot < 3)
                    gather_acc = (gather_acc | (byt << (8 * slot))) & 32'hffffff;
                b0 = gather_acc & 8'hff;
                b1 = (gather_acc >> 8) & 8'hff;
                b2 = (gather_acc >> 16) & 8'hff;
                r  = 0;
                g  = 0;
                bl = 0;
                a  = 0;
                case (kind_r)
                    KIND_MAP8:
                    begin
                        c  = pal_mem[b0];
                        r  = (c >> 16) & 8'hff;
                        g  = (c >> 8) & 8'hff;
                        bl = c & 8'hff;
                    end
                    KIND_TRUE16:
                    begin
                        c  = b0 | (b1 << 8);
                        r  = (((c & 16'h7c00) >> 10) << 3) & 8'hff;
                        g  = (((c & 16'h03e0) >> 5) << 3) & 8'hff;
                        bl = ((c & 16'h001f) << 3) & 8'hff;
                    end
                    KIND_TRUE24:
                    begin
                        r  = b2;
                        g  = b1;
                        bl = b0;
                    end
                    KIND_TRUE32:
                    begin
                        r  = b2;
                        g  = b1;
                        bl = b0;
                        a  = byt;
                    end
                    KIND_GREY8:
                        r = b0;
                    KIND_GREY16:
                    begin
                        r = b0;
                        g = b1;
                    end
                    default: ;
                endcase
                slot       = 0;
                gather_acc = 0;
                // run pixels repeat, clamped to what the image has left
                if (rle_r && pkt_run)
                begin
                    rep      = (pkt_left > px_left) ? px_left : pkt_left;
                    pkt_left = 0;
                    hdr_due  = 1'b1;
                end
                else
                begin
                    rep = 1;
                    if (rle_r)
                    begin
                        pkt_left = (pkt_left - 1) & 8'hff;
                        if (pkt_left == 0)
                            hdr_due = 1'b1;
                    end
                end
                px_left = (px_left - rep) & 32'hffffff;
                p.chan_first   = 8'(r);
                p.chan_second  = 8'(g);
                p.chan_third   = 8'(bl);
                p.chan_fourth  = 8'(a);
                p.repeat_count = 8'(rep);
                p.image_last   = (px_left == 0);
                pixels_due.push_back(p);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    // compare one output word with the oldest expected pixel
    task automatic check_pixel(input pix_word_t got);
        pix_word_t want;
        if (pixels_due.size() == 0)
            report_mismatch("pixel word with none expected", got, 0);
        else
        begin
            want = pixels_due.pop_front();
            if (got.chan_first !== want.chan_first)
                report_mismatch("chan_first", got.chan_first, want.chan_first);
            if (got.chan_second !== want.chan_second)
                report_mismatch("chan_second", got.chan_second, want.chan_second);
            if (got.chan_third !== want.chan_third)
                report_mismatch("chan_third", got.chan_third, want.chan_third);
            if (got.chan_fourth !== want.chan_fourth)
                report_mismatch("chan_fourth", got.chan_fourth, want.chan_fourth);
            if (got.repeat_count !== want.repeat_count)
                report_mismatch("repeat_count", got.repeat_count, want.repeat_count);
            if (got.image_last !== want.image_last)
                report_mismatch("image_last", got.image_last, want.image_last);
        end
    endtask

    // monitor: check taken pixel words, predict from taken item words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && pix_ready)
                check_pixel(pix);
            if (item_valid && item_ready)
                decode_word(item);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pix_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            pix_ready <= 1'b0;
        end
        else if (quiet || $urandom_range(0, 99) < 80)
            pix_ready <= 1'b1;
        else
        begin
            stall_left = pick_gap();
            pix_ready <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tga_pixel_stream_decoder_core: mismatch");
            $finish;
        end
    end

    // offer one word, return at the edge that takes it
    task automatic send_word(input item_word_t w);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic send_body(input item_word_t w);
        send_word(w);
        body_words++;
    endtask

    // stop offering until every expected pixel is out and the pipe is empty
    task automatic wait_all_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_KIND:  kind_r  = val[2:0];
            CFG_RLE:   rle_r   = val[0];
            CFG_TOTAL: total_r = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [2:0] kind, input bit rle, input logic [23:0] total);
        wait_all_results();
        write_reg(CFG_KIND, CFG_DATA_W'(kind));
        write_reg(CFG_RLE, CFG_DATA_W'(rle));
        write_reg(CFG_TOTAL, total);
    endtask

    // bytes of one pixel, with the odd stray word in between
    task automatic send_pixel(input int unsigned need);
        for (int j = 0; j < need; j++)
        begin
            if ($urandom_range(0, 99) < 4)
                send_word(noise_word());
            send_body(data_word(pick_byte()));
        end
    endtask

    // data before any start and a zero pixel total produce nothing, then two 24-bit pixels
    task automatic test_reset_defaults();
        send_word(data_word(8'hff));
        send_word(start_word());
        send_word(data_word(8'h00));
        configure(KIND_TRUE24, 1'b0, 24'd2);
        send_word(start_word());
        repeat (3) send_word(data_word(8'h00));
        repeat (3) send_word(data_word(8'hff));
        // bytes after the last pixel are dropped
        send_word(data_word(8'ha5));
    endtask

    // fill the whole colormap, then read its corners back
    task automatic test_palette_fill();
        logic [23:0] entry;
        for (int i = 0; i < 256; i++)
        begin
            entry = (i == 0) ? 24'h000000 : (i == 255) ? 24'hffffff : 24'($urandom);
            send_word(map_word(8'(i), entry));
        end
        configure(KIND_MAP8, 1'b0, 24'd4);
        send_word(start_word());
        send_word(data_word(8'h00));
        send_word(data_word(8'hff));
        send_word(data_word(pick_byte()));
        send_word(data_word(pick_byte()));
    endtask

    // one raw pixel of every other kind, and an unused kind that drops bytes
    task automatic test_each_kind();
        logic [2:0] kinds [6];
        int unsigned need;
        kinds = '{KIND_TRUE16, KIND_TRUE24, KIND_TRUE32, KIND_GREY8, KIND_GREY16, KIND_SPARE};
        foreach (kinds[k])
        begin
            configure(kinds[k], 1'b0, 24'd1);
            send_word(start_word());
            need = pixel_width(kinds[k]);
            if (need == 0)
                need = 2;
            send_word(data_word(8'hff));
            for (int j = 1; j < need; j++)
                send_word(data_word(8'($urandom)));
        end
    endtask

    // run clamped to the image end, single packets, raw packet cut short
    task automatic test_rle_packets();
        configure(KIND_GREY16, 1'b1, 24'd5);
        send_word(start_word());
        send_word(data_word(HDR_RUN_BIT | HDR_COUNT_MASK));
        send_word(data_word(8'h3c));
        send_word(data_word(8'hc3));
        configure(KIND_GREY8, 1'b1, 24'd3);
        send_word(start_word());
        send_word(data_word(8'h00));
        send_word(data_word(8'h11));
        send_word(data_word(HDR_RUN_BIT));
        send_word(data_word(8'h22));
        send_word(noise_word());
        send_word(data_word(HDR_COUNT_MASK));
        send_word(data_word(8'h33));
        send_word(data_word(8'h44));
    endtask

    // long receiver hold-off while words keep coming, then a sender pause
    task automatic test_backpressure();
        configure(KIND_GREY8, 1'b0, 24'd200);
        quiet = 1'b1;
        send_word(start_word());
        hold_asks <= hold_asks + 1;
        repeat (60) send_body(data_word(pick_byte()));
        repeat (20) send_body(data_word(pick_byte()));
        wait_all_results();
        quiet = 1'b0;
        repeat (30) send_body(data_word(pick_byte()));
    endtask

    // random images: mostly well-formed packet streams, some noise and breaks
    task automatic test_random_images();
        logic [2:0]  kind;
        logic [23:0] total;
        bit          rle;
        bit          run;
        int unsigned need;
        int unsigned left;
        int unsigned cnt;
        int unsigned n;
        int          r;
        while (body_words < RANDOM_WORDS)
        begin
            r    = $urandom_range(0, 99);
            kind = (r < 4) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
            rle  = $urandom_range(0, 1);
            r    = $urandom_range(0, 99);
            if (r < 5)
                total = 24'd0;
            else if (r < 9)
                total = 24'hffffff;
            else if (r < 15)
                total = 24'($urandom_range(25, 200));
            else
                total = 24'($urandom_range(1, 24));
            configure(kind, rle, total);
            quiet = ($urandom_range(0, 7) == 0);
            // now and then the old image carries on under the new settings
            if ($urandom_range(0, 9) != 0)
                send_word(start_word());
            left = (total > 40) ? 40 : total;
            need = pixel_width(kind);
            if (need == 0)
                need = 2;
            while (left > 0)
            begin
                if ($urandom_range(0, 149) == 0)
                    break;
                if (rle)
                begin
                    run = $urandom_range(0, 1);
                    cnt = pick_count(run);
                    send_body(data_word(8'(cnt - 1) | (run ? HDR_RUN_BIT : 8'h00)));
                    if (run)
                    begin
                        send_pixel(need);
                        left -= (cnt > left) ? left : cnt;
                    end
                    else
                    begin
                        n = (cnt > left) ? left : cnt;
                        repeat (n) send_pixel(need);
                        left -= n;
                    end
                end
                else
                begin
                    send_pixel(need);
                    left--;
                end
            end
            // trailing bytes past the image end
            if ($urandom_range(0, 9) < 3)
                repeat ($urandom_range(1, 4)) send_word(data_word(pick_byte()));
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        int waited;
        kind_r     = KIND_TRUE24;
        rle_r      = 1'b0;
        total_r    = 0;
        pkt_left   = 0;
        pkt_run    = 1'b0;
        hdr_due    = 1'b1;
        slot       = 0;
        gather_acc = 0;
        px_left    = 0;
        errors     = 0;
        body_words = 0;
        quiet      = 1'b0;
        hold_asks  = 0;
        hold_seen  = 0;
        hold_left  = 0;
        stall_left = 0;
        cycle_count = 0;
        waited     = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_palette_fill();
        test_each_kind();
        test_rle_packets();
        test_backpressure();
        test_random_images();

        // drain, then allow for the pipe latency
        item_valid <= 1'b0;
        @(posedge clk);
        while (pixels_due.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
        if (pixels_due.size() != 0)
            report_mismatch("expected pixels never delivered", pixels_due.size(), 0);

        if (errors == 0)
            $display("tga_pixel_stream_decoder_core: match");
        else
            $display("tga_pixel_stream_decoder_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
